>>> sv/stable_priority_queue_top_macros.svh
// Assertion macros shared by the queue checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/spq_pkg.sv
// Shared types and constants of the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

	localparam int DEFAULT_DEPTH = 16;
	localparam int PRI_W         = 4;
	localparam int CID_W         = 32;
	localparam int CNT_W         = 16;
	localparam int OCC_W         = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [PRI_W-1:0]   new_priority;
		logic [CID_W-1:0]   new_client_id;
		logic [CNT_W-1:0]   new_item_count;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PRI_W-1:0]   head_priority;
		logic [CID_W-1:0]   head_client_id;
		logic [CNT_W-1:0]   head_item_count;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    insert;
		logic    remove;
		logic    emit;
		status_t rsp_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
	} stat_t;

endpackage

>>> sv/spq_ctrl.sv
// Controller of the stable priority queue: request sequencing and output valid.
// Depends on spq_pkg; drives spq_datapath through cmd_t, reads stat_t.
module spq_ctrl import spq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rsp_status = ST_INSERTED;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold the request until the result register is free
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
					if (!stat.is_remove) begin
						if (stat.full) begin
							cmd.rsp_status = ST_FULL;
						end else begin
							cmd.insert     = 1'b1;
							cmd.rsp_status = ST_INSERTED;
						end
					end else begin
						if (stat.empty) begin
							cmd.rsp_status = ST_EMPTY;
						end else begin
							cmd.remove     = 1'b1;
							cmd.rsp_status = ST_REMOVED;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/spq_datapath.sv
// Datapath of the stable priority queue: sorted row of entry cells,
// fill count, request register and result register. Depends on spq_pkg.
module spq_datapath import spq_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  in_data,
	input  cmd_t  cmd,
	output stat_t stat,
	output rsp_t  out_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [PRI_W-1:0] pri_q [DEPTH];
	logic [CID_W-1:0] cid_q [DEPTH];
	logic [CNT_W-1:0] cnt_q [DEPTH];
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	req_t             req_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic [DEPTH-1:0] held;
	logic [DEPTH-1:0] le;

	assign stat.is_remove = (req_q.action == ACT_REMOVE);
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.empty     = (count_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
	end

	// each cell: held entry with priority not above the new one stays in front
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign held[g] = (count_q > CW'(g));
		assign le[g]   = held[g] && (pri_q[g] <= req_q.new_priority);

		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (!le[0]) begin
						pri_q[0] <= req_q.new_priority;
						cid_q[0] <= req_q.new_client_id;
						cnt_q[0] <= req_q.new_item_count;
					end
				end else if (cmd.remove && DEPTH > 1) begin
					pri_q[0] <= pri_q[1];
					cid_q[0] <= cid_q[1];
					cnt_q[0] <= cnt_q[1];
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (!le[g] && le[g-1]) begin
						pri_q[g] <= req_q.new_priority;
						cid_q[g] <= req_q.new_client_id;
						cnt_q[g] <= req_q.new_item_count;
					end else if (held[g-1] && !le[g-1]) begin
						// advance: the entry in front moves back one slot
						pri_q[g] <= pri_q[g-1];
						cid_q[g] <= cid_q[g-1];
						cnt_q[g] <= cnt_q[g-1];
					end
				end else if (cmd.remove) begin
					if (g < DEPTH - 1) begin
						pri_q[g] <= pri_q[(g < DEPTH - 1) ? g + 1 : g];
						cid_q[g] <= cid_q[(g < DEPTH - 1) ? g + 1 : g];
						cnt_q[g] <= cnt_q[(g < DEPTH - 1) ? g + 1 : g];
					end
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.insert) begin
			count_d = count_q + CW'(1);
		end else if (cmd.remove) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		rsp_d.status          = cmd.rsp_status;
		rsp_d.head_priority   = pri_q[0];
		rsp_d.head_client_id  = cid_q[0];
		rsp_d.head_item_count = cnt_q[0];
		rsp_d.occupancy       = OCC_W'(count_d);
		case (cmd.rsp_status)
			ST_INSERTED: begin
				if (!le[0]) begin
					rsp_d.head_priority   = req_q.new_priority;
					rsp_d.head_client_id  = req_q.new_client_id;
					rsp_d.head_item_count = req_q.new_item_count;
				end
			end
			ST_EMPTY: begin
				rsp_d.head_priority   = '0;
				rsp_d.head_client_id  = '0;
				rsp_d.head_item_count = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign out_data = rsp_q;

endmodule

>>> sv/stable_priority_queue_top.sv
// Stable priority queue: up to QUEUE_DEPTH entries kept sorted by priority, smaller value
// first, equal priorities in arrival order. A request is accepted when the block is idle and
// executes in the execute state that follows; no new request is accepted until the last one has
// executed. The result is registered and may wait for the consumer while the next request is
// accepted; execution holds only while an older result is still stalled. Inserts into a full
// queue are dropped with status full.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module stable_priority_queue_top import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

>>> sv/spq_checker.sv
// Port-level checks of the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_top_macros.svh.
`include "stable_priority_queue_top_macros.svh"

module spq_checker import spq_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input req_t in_data,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	// stalled result holds
	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// one request in flight: stall right after an accept
	`SPQ_ASSERT_NEXT(a_one_request, in_valid && !in_stall, in_stall, "second request taken while busy")

	// remove on empty reports zero head and occupancy
	`SPQ_ASSERT_SAME(a_empty_zero, out_valid && out_data.status == ST_EMPTY, out_data.occupancy == '0 && out_data.head_priority == '0 && out_data.head_client_id == '0 && out_data.head_item_count == '0, "empty result not zero")

	// full is reported only at full occupancy
	`SPQ_ASSERT_SAME(a_full_occ, out_valid && out_data.status == ST_FULL, out_data.occupancy == FULL_OCC, "full status at wrong occupancy")

endmodule

bind stable_priority_queue_top spq_checker #(.DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
